// File: hdl/qwt_pkg.sv
// ----------------------------------------------------------------------------
// qwt_pkg
// Shared constants and item types for the quoted word tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qwt_pkg;

  // Longest line that offsets and counts can express before saturating.
  localparam int unsigned MAX_LINE       = 4096;
  // Opening backtick runs are counted up to this length; a longer run saturates.
  localparam int unsigned MAX_ALT_QUOTES = 15;

  // Offset and count widths follow from the line length.
  localparam int unsigned POS_W   = $clog2(MAX_LINE + 1);
  localparam int unsigned START_W = $clog2(MAX_LINE);
  localparam int unsigned RUN_W   = $clog2(MAX_ALT_QUOTES + 1);

  // Byte codes with a meaning of their own.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One input item: a line byte and the end-of-line mark.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } item_t;

  // One result item.
  typedef struct packed {
    logic               word_valid;
    logic [START_W-1:0] word_start;
    logic [POS_W-1:0]   word_length;
    logic [POS_W-1:0]   word_end;
    logic               quoted;
    logic               quote_closed;
    logic               tick_quoted;
    logic [POS_W-1:0]   word_count;
    logic               line_end;
  } res_t;

  // Flow control between the pipeline stages.
  typedef struct packed {
    logic advance;  // the input stage may hand its item on this cycle
    logic load;     // a result item is offered to the result register this cycle
  } flow_t;

endpackage

// File: hdl/qwt_ifs.sv
// ----------------------------------------------------------------------------
// qwt_ifs
// Valid/ready channel interfaces for line bytes and word results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Line byte channel.
interface qwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

// Word result channel.
interface qwt_out_if;
  import qwt_pkg::*;

  logic               valid;
  logic               ready;
  logic               word_valid;
  logic [START_W-1:0] word_start;
  logic [POS_W-1:0]   word_length;
  logic [POS_W-1:0]   word_end;
  logic               quoted;
  logic               quote_closed;
  logic               tick_quoted;
  logic [POS_W-1:0]   word_count;
  logic               line_end;

  modport source (
    output valid, output word_valid, output word_start, output word_length,
    output word_end, output quoted, output quote_closed, output tick_quoted,
    output word_count, output line_end, input ready
  );
  modport sink (
    input valid, input word_valid, input word_start, input word_length,
    input word_end, input quoted, input quote_closed, input tick_quoted,
    input word_count, input line_end, output ready
  );
endinterface

// File: hdl/qwt_in_stage.sv
// ----------------------------------------------------------------------------
// qwt_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qwt_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qwt_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output qwt_pkg::item_t item
);
  import qwt_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // A new item may enter when the register is empty or is being drained.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, loaded on acceptance only.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: hdl/qwt_parser.sv
// ----------------------------------------------------------------------------
// qwt_parser
// Tokenizer state and the single-pass update for one line byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qwt_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  qwt_pkg::item_t item,
  output logic           res_present,
  output qwt_pkg::res_t  res
);
  import qwt_pkg::*;

  typedef enum logic [7:0] {
    PH_SKIP     = 8'b0000_0001,
    PH_OPEN_ALT = 8'b0000_0010,
    PH_PLAIN    = 8'b0000_0100,
    PH_DBL      = 8'b0000_1000,
    PH_ESC      = 8'b0001_0000,
    PH_ALT      = 8'b0010_0000,
    PH_TRAIL    = 8'b0100_0000,
    PH_DRAIN    = 8'b1000_0000
  } phase_t;

  localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(MAX_LINE);
  localparam logic [START_W-1:0] START_MAX = START_W'(MAX_LINE - 1);
  localparam logic [RUN_W-1:0]   RUN_MAX   = RUN_W'(MAX_ALT_QUOTES);

  // Add with saturation at the maximum line length.
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [RUN_W:0]   b);
    logic [POS_W:0] s;
    s = {1'b0, a} + (POS_W + 1)'(b);
    return (s > {1'b0, POS_MAX}) ? POS_MAX : s[POS_W-1:0];
  endfunction

  // Space, tab, line feed, vertical tab, form feed and carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Offset clamped to the range of a start field.
  function automatic logic [START_W-1:0] clamp_start(input logic [POS_W-1:0] p);
    return (p > POS_W'(MAX_LINE - 1)) ? START_MAX : p[START_W-1:0];
  endfunction

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   position_r, position_nxt;
  logic [START_W-1:0] start_pos_r, start_pos_nxt;
  logic [POS_W-1:0]   content_length_r, content_length_nxt;
  logic [RUN_W-1:0]   open_run_r, open_run_nxt;
  logic [RUN_W-1:0]   close_run_r, close_run_nxt;
  logic               dbl_flag_r, dbl_flag_nxt;
  logic               alt_flag_r, alt_flag_nxt;
  logic               closed_flag_r, closed_flag_nxt;
  logic               word_pending_r, word_pending_nxt;
  logic [POS_W-1:0]   words_seen_r, words_seen_nxt;

  // Single-pass update of the state for the byte in the input register.
  always_comb begin
    logic [7:0]       c;
    logic             emit;
    logic             line_done;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] end_off;
    logic [RUN_W-1:0] run_inc;

    c         = item.char_in;
    emit      = 1'b0;
    line_done = 1'b0;
    pos_inc   = sat_add(position_r, (RUN_W + 1)'(1));
    end_off   = '0;
    run_inc   = close_run_r + RUN_W'(1);

    phase_nxt          = phase_r;
    position_nxt       = position_r;
    start_pos_nxt      = start_pos_r;
    content_length_nxt = content_length_r;
    open_run_nxt       = open_run_r;
    close_run_nxt      = close_run_r;
    dbl_flag_nxt       = dbl_flag_r;
    alt_flag_nxt       = alt_flag_r;
    closed_flag_nxt    = closed_flag_r;
    word_pending_nxt   = word_pending_r;
    words_seen_nxt     = words_seen_r;
    res_present        = 1'b0;
    res                = '0;

    if (phase_r == PH_DRAIN) begin
      // After an early zero byte, wait for the end of the line.
      if (item.last) begin
        phase_nxt          = PH_SKIP;
        position_nxt       = '0;
        start_pos_nxt      = '0;
        content_length_nxt = '0;
        open_run_nxt       = '0;
        close_run_nxt      = '0;
        dbl_flag_nxt       = 1'b0;
        alt_flag_nxt       = 1'b0;
        closed_flag_nxt    = 1'b0;
        word_pending_nxt   = 1'b0;
        words_seen_nxt     = '0;
      end
    end else begin
      if (c == CH_NUL) begin
        line_done = 1'b1;
        end_off   = position_r;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            if (is_ws(c)) begin
              phase_nxt = PH_SKIP;
            end else if (c == CH_DQUOTE) begin
              dbl_flag_nxt  = 1'b1;
              start_pos_nxt = clamp_start(pos_inc);
              phase_nxt     = PH_DBL;
            end else if (c == CH_BTICK) begin
              alt_flag_nxt = 1'b1;
              open_run_nxt = RUN_W'(1);
              phase_nxt    = PH_OPEN_ALT;
            end else begin
              start_pos_nxt      = clamp_start(position_r);
              word_pending_nxt   = 1'b1;
              content_length_nxt = sat_add(content_length_r, (RUN_W + 1)'(1));
              phase_nxt          = (c == CH_BSLASH) ? PH_ESC : PH_PLAIN;
            end
          end
          PH_OPEN_ALT: begin
            if (c == CH_BTICK) begin
              if (open_run_r < RUN_MAX) begin
                open_run_nxt = open_run_r + RUN_W'(1);
              end
            end else begin
              start_pos_nxt      = clamp_start(position_r);
              word_pending_nxt   = 1'b1;
              content_length_nxt = sat_add(content_length_r, (RUN_W + 1)'(1));
              close_run_nxt      = '0;
              phase_nxt          = PH_ALT;
            end
          end
          PH_PLAIN: begin
            if (is_ws(c)) begin
              emit    = 1'b1;
              end_off = position_r;
            end else begin
              content_length_nxt = sat_add(content_length_r, (RUN_W + 1)'(1));
              if (c == CH_BSLASH) begin
                phase_nxt = PH_ESC;
              end
            end
          end
          PH_DBL: begin
            word_pending_nxt = 1'b1;
            if (c == CH_DQUOTE) begin
              closed_flag_nxt = 1'b1;
              phase_nxt       = PH_TRAIL;
            end else begin
              content_length_nxt = sat_add(content_length_r, (RUN_W + 1)'(1));
              if (c == CH_BSLASH) begin
                phase_nxt = PH_ESC;
              end
            end
          end
          PH_ESC: begin
            content_length_nxt = sat_add(content_length_r, (RUN_W + 1)'(1));
            phase_nxt          = dbl_flag_r ? PH_DBL : PH_PLAIN;
          end
          PH_ALT: begin
            // A closing run must match the opening run; a shorter run is text.
            if (c == CH_BTICK) begin
              if (run_inc >= open_run_r) begin
                closed_flag_nxt = 1'b1;
                close_run_nxt   = '0;
                phase_nxt       = PH_TRAIL;
              end else begin
                close_run_nxt = run_inc;
              end
            end else begin
              content_length_nxt = sat_add(content_length_r,
                                           {1'b0, close_run_r} + (RUN_W + 1)'(1));
              close_run_nxt      = '0;
            end
          end
          PH_TRAIL: begin
            if (is_ws(c)) begin
              emit    = 1'b1;
              end_off = position_r;
            end
          end
          default: begin
            phase_nxt = PH_SKIP;
          end
        endcase
      end
      position_nxt = pos_inc;

      // A marked last byte ends the line as if a zero byte followed it.
      if (!line_done && item.last) begin
        line_done = 1'b1;
        if (!emit) begin
          end_off = pos_inc;
        end
      end

      // Backticks still open at line end count as word text.
      if (line_done && !emit && word_pending_nxt) begin
        content_length_nxt = sat_add(content_length_nxt, {1'b0, close_run_nxt});
      end

      // Assemble the result item.
      res_present = emit || line_done;
      if (emit || (line_done && word_pending_nxt)) begin
        words_seen_nxt   = sat_add(words_seen_r, (RUN_W + 1)'(1));
        res.word_valid   = 1'b1;
        res.word_start   = start_pos_nxt;
        res.word_length  = content_length_nxt;
        res.word_end     = end_off;
        res.quoted       = dbl_flag_nxt || alt_flag_nxt;
        res.quote_closed = closed_flag_nxt;
        res.tick_quoted  = alt_flag_nxt;
      end
      res.word_count = words_seen_nxt;
      res.line_end   = line_done;

      // Clear the word after it is reported, and the line at its end.
      if (emit || line_done) begin
        start_pos_nxt      = '0;
        content_length_nxt = '0;
        open_run_nxt       = '0;
        close_run_nxt      = '0;
        dbl_flag_nxt       = 1'b0;
        alt_flag_nxt       = 1'b0;
        closed_flag_nxt    = 1'b0;
        word_pending_nxt   = 1'b0;
        phase_nxt          = PH_SKIP;
      end
      if (line_done) begin
        position_nxt   = '0;
        words_seen_nxt = '0;
        if ((c == CH_NUL) && !item.last) begin
          phase_nxt = PH_DRAIN;
        end
      end
    end
  end

  // State registers, updated once per consumed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_SKIP;
      position_r       <= '0;
      start_pos_r      <= '0;
      content_length_r <= '0;
      open_run_r       <= '0;
      close_run_r      <= '0;
      dbl_flag_r       <= 1'b0;
      alt_flag_r       <= 1'b0;
      closed_flag_r    <= 1'b0;
      word_pending_r   <= 1'b0;
      words_seen_r     <= '0;
    end else if (fire) begin
      phase_r          <= phase_nxt;
      position_r       <= position_nxt;
      start_pos_r      <= start_pos_nxt;
      content_length_r <= content_length_nxt;
      open_run_r       <= open_run_nxt;
      close_run_r      <= close_run_nxt;
      dbl_flag_r       <= dbl_flag_nxt;
      alt_flag_r       <= alt_flag_nxt;
      closed_flag_r    <= closed_flag_nxt;
      word_pending_r   <= word_pending_nxt;
      words_seen_r     <= words_seen_nxt;
    end
  end

`ifndef SYNTH
  // A line end leaves the offset at the start of a fresh line.
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_present && res.line_end |=> position_r == '0 && words_seen_r == '0)
    else $error("line end did not clear the offset and count");

  // Inside a backtick quote the partial closing run stays below the opening run.
  a_close_run_short: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ALT |-> close_run_r < open_run_r)
    else $error("closing run reached the opening run without closing");

  // A reported word is always counted.
  a_word_counted: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_present && res.word_valid |-> res.word_count != '0)
    else $error("word reported with a zero count");

  // The offset never passes its saturation point.
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= POS_MAX)
    else $error("offset beyond the line length limit");
`endif

endmodule

// File: hdl/qwt_out_stage.sv
// ----------------------------------------------------------------------------
// qwt_out_stage
// Result register: holds a finished word result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qwt_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  qwt_pkg::res_t res_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output qwt_pkg::res_t res_out
);
  import qwt_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The register may be written when empty or when its item leaves now.
  assign free      = !valid_r || out_ready;
  assign valid_nxt = free ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// File: hdl/quoted_word_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_word_tokenizer
// Splits a command line, one byte per item, into words with quote flags.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                   Handshake
//   in_ch     sink       char_in[7:0], last                        valid/ready
//   out_ch    source     word_valid, word_start[11:0],             valid/ready
//                        word_length[12:0], word_end[12:0], quoted,
//                        quote_closed, tick_quoted, word_count[12:0],
//                        line_end
//
// One byte is accepted per cycle while out_ch does not stall; a result passes
// the input register, then the one-byte state update, then the result
// register. Reset is synchronous and clears the parser state at once; no
// clearing pass follows. When out_ch stalls, the result register holds,
// the input register keeps one more byte, and then in_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_word_tokenizer (
  input logic      clk,
  input logic      rst_n,
  qwt_in_if.sink   in_ch,
  qwt_out_if.source out_ch
);
  import qwt_pkg::*;

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  res_present;
  res_t  res;
  res_t  res_out;
  logic  out_free;
  flow_t flow;

  assign in_item.char_in = in_ch.char_in;
  assign in_item.last    = in_ch.last;

  // The input stage moves on whenever the result register can take an item;
  // bytes that give no result are simply consumed.
  assign flow.advance = out_free;
  assign flow.load    = item_valid && res_present;

  qwt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (flow.advance),
    .item_valid (item_valid),
    .item       (item)
  );

  qwt_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (item_valid && flow.advance),
    .item        (item),
    .res_present (res_present),
    .res         (res)
  );

  qwt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (flow.load),
    .res_in    (res),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_out   (res_out)
  );

  // Result fields onto the channel.
  assign out_ch.word_valid   = res_out.word_valid;
  assign out_ch.word_start   = res_out.word_start;
  assign out_ch.word_length  = res_out.word_length;
  assign out_ch.word_end     = res_out.word_end;
  assign out_ch.quoted       = res_out.quoted;
  assign out_ch.quote_closed = res_out.quote_closed;
  assign out_ch.tick_quoted  = res_out.tick_quoted;
  assign out_ch.word_count   = res_out.word_count;
  assign out_ch.line_end     = res_out.line_end;

endmodule

// File: tb/quoted_word_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_tb
// Self-checking bench for the quoted word tokenizer. A short table of
// hand-picked bytes covers empty lines, quoting, escapes, early zero bytes
// and lone quotes. Random command lines follow, each built from plain,
// double-quoted and backtick-quoted words with some noise mixed in. Every
// result is checked field by field against a local model of the parser, or against NO_WORD_END on typed rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_word_tokenizer_tb;

  import qwt_pkg::*;

  // Quiet cycles allowed before the run is declared hung.
  localparam int unsigned IDLE_LIMIT  = 3000;
  // Input items per random phase, not counting bytes that the block ignores.
  localparam int unsigned PHASE_ITEMS = 550;

  // Parser states of the local model.
  typedef enum logic [7:0] {
    SCAN_GAP     = 8'b0000_0001,
    SCAN_TICKS   = 8'b0000_0010,
    IN_PLAIN     = 8'b0000_0100,
    IN_DQUOTE    = 8'b0000_1000,
    AFTER_BSLASH = 8'b0001_0000,
    IN_TICKS     = 8'b0010_0000,
    SKIP_TAIL    = 8'b0100_0000,
    WAIT_LAST    = 8'b1000_0000
  } scan_state_t;

  // One row of the directed table; typed marks rows whose result is known.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
  } dir_row_t;

  // Result of a line that ends without a word, with no words before it.
  localparam res_t NO_WORD_END = '{word_valid: 1'b0, word_start: '0, word_length: '0,
                                   word_end: '0, quoted: 1'b0, quote_closed: 1'b0,
                                   tick_quoted: 1'b0, word_count: '0, line_end: 1'b1};

  logic clk;
  logic rst_n;
  logic drv_typed;

  qwt_in_if  in_if ();
  qwt_out_if out_if ();

  quoted_word_tokenizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Model state.
  scan_state_t scan_state;
  int unsigned line_pos, word_from, word_len, open_ticks, close_ticks, word_tally;
  bit          by_dquote, by_ticks, got_close, word_open;

  res_t        pending_words[$];
  item_t       line_q[$];
  int unsigned gap_pct, stall_pct;
  int unsigned quiet_cycles;
  int unsigned mismatches, bytes_taken, words_checked, ends_checked, lines_sent;

  // Directed table: empty line, escaped double quotes with trailing bytes,
  // backtick pairs with a single backtick inside, last on a non-blank byte,
  // a word ended by blank with last, a zero byte without last and the bytes
  // it drains, a lone double quote, and an unclosed backtick run.
  dir_row_t plan [0:27] = '{
    '{8'h00,     1'b1, 1'b1}, '{CH_SPACE,  1'b0, 1'b0}, '{CH_DQUOTE, 1'b0, 1'b0},
    '{8'h78,     1'b0, 1'b0}, '{CH_BSLASH, 1'b0, 1'b0}, '{CH_DQUOTE, 1'b0, 1'b0},
    '{CH_DQUOTE, 1'b0, 1'b0}, '{8'h71,     1'b0, 1'b0}, '{CH_TAB,    1'b0, 1'b0},
    '{CH_BTICK,  1'b0, 1'b0}, '{CH_BTICK,  1'b0, 1'b0}, '{8'h61,     1'b0, 1'b0},
    '{CH_BTICK,  1'b0, 1'b0}, '{8'h62,     1'b0, 1'b0}, '{CH_BTICK,  1'b0, 1'b0},
    '{CH_BTICK,  1'b0, 1'b0}, '{8'hFF,     1'b1, 1'b0}, '{CH_BSLASH, 1'b0, 1'b0},
    '{CH_SPACE,  1'b0, 1'b0}, '{CH_SPACE,  1'b1, 1'b0}, '{CH_NUL,    1'b0, 1'b1},
    '{8'h7A,     1'b0, 1'b0}, '{8'h80,     1'b1, 1'b0}, '{CH_DQUOTE, 1'b1, 1'b1},
    '{CH_BTICK,  1'b0, 1'b0}, '{CH_BTICK,  1'b0, 1'b0}, '{8'h6B,     1'b0, 1'b0},
    '{CH_BTICK,  1'b1, 1'b0}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic int unsigned cap_line(input int unsigned v);
    return (v > MAX_LINE) ? MAX_LINE : v;
  endfunction

  function automatic void drop_word();
    word_from   = 0;
    word_len    = 0;
    open_ticks  = 0;
    close_ticks = 0;
    by_dquote   = 1'b0;
    by_ticks    = 1'b0;
    got_close   = 1'b0;
    word_open   = 1'b0;
  endfunction

  function automatic void restart_line();
    drop_word();
    scan_state = SCAN_GAP;
    line_pos   = 0;
    word_tally = 0;
  endfunction

  // Fill in a word result and count the word.
  function automatic void fill_word(output res_t w, input int unsigned end_off);
    word_tally     = cap_line(word_tally + 1);
    w.word_valid   = 1'b1;
    w.word_start   = word_from[START_W-1:0];
    w.word_length  = word_len[POS_W-1:0];
    w.word_end     = end_off[POS_W-1:0];
    w.quoted       = by_dquote || by_ticks;
    w.quote_closed = got_close;
    w.tick_quoted  = by_ticks;
    w.word_count   = word_tally[POS_W-1:0];
    w.line_end     = 1'b0;
  endfunction

  // Advance the model by one byte; returns 1 when a result is due.
  function automatic bit tokenize_byte(input logic [7:0] ch, input logic fin,
                                       output res_t word);
    bit          emit = 1'b0;
    bit          done = 1'b0;
    int unsigned pos, nxt, here;
    int unsigned end_off = 0;
    word = '0;
    if (scan_state == WAIT_LAST) begin
      if (fin) restart_line();
      return 1'b0;
    end
    pos  = line_pos;
    nxt  = cap_line(pos + 1);
    here = (pos > MAX_LINE - 1) ? MAX_LINE - 1 : pos;

    if (ch == CH_NUL) begin
      done    = 1'b1;
      end_off = pos;
    end else begin
      case (scan_state)
        SCAN_GAP: begin
          if (ch == CH_DQUOTE) begin
            by_dquote  = 1'b1;
            word_from  = (nxt > MAX_LINE - 1) ? MAX_LINE - 1 : nxt;
            scan_state = IN_DQUOTE;
          end else if (ch == CH_BTICK) begin
            by_ticks   = 1'b1;
            open_ticks = 1;
            scan_state = SCAN_TICKS;
          end else if (!is_blank(ch)) begin
            word_from  = here;
            word_open  = 1'b1;
            word_len   = cap_line(word_len + 1);
            scan_state = (ch == CH_BSLASH) ? AFTER_BSLASH : IN_PLAIN;
          end
        end
        SCAN_TICKS: begin
          if (ch == CH_BTICK) begin
            if (open_ticks < MAX_ALT_QUOTES) open_ticks++;
          end else begin
            word_from   = here;
            word_open   = 1'b1;
            word_len    = cap_line(word_len + 1);
            close_ticks = 0;
            scan_state  = IN_TICKS;
          end
        end
        IN_PLAIN: begin
          if (is_blank(ch)) begin
            emit    = 1'b1;
            end_off = pos;
          end else begin
            word_len = cap_line(word_len + 1);
            if (ch == CH_BSLASH) scan_state = AFTER_BSLASH;
          end
        end
        IN_DQUOTE: begin
          word_open = 1'b1;
          if (ch == CH_DQUOTE) begin
            got_close  = 1'b1;
            scan_state = SKIP_TAIL;
          end else begin
            word_len = cap_line(word_len + 1);
            if (ch == CH_BSLASH) scan_state = AFTER_BSLASH;
          end
        end
        AFTER_BSLASH: begin
          word_len   = cap_line(word_len + 1);
          scan_state = by_dquote ? IN_DQUOTE : IN_PLAIN;
        end
        IN_TICKS: begin
          if (ch == CH_BTICK) begin
            close_ticks++;
            if (close_ticks >= open_ticks) begin
              got_close   = 1'b1;
              close_ticks = 0;
              scan_state  = SKIP_TAIL;
            end
          end else begin
            // A shorter backtick run was word text after all.
            word_len    = cap_line(word_len + close_ticks + 1);
            close_ticks = 0;
          end
        end
        default: begin
          if (is_blank(ch)) begin
            emit    = 1'b1;
            end_off = pos;
          end
        end
      endcase
    end
    line_pos = nxt;

    if (!done && fin) begin
      done = 1'b1;
      if (!emit) end_off = nxt;
    end
    if (emit) begin
      fill_word(word, end_off);
      drop_word();
      scan_state = SCAN_GAP;
    end
    if (!done) return emit;

    // The line ends here: report the open word, or just the count.
    if (!emit) begin
      if (word_open) begin
        word_len = cap_line(word_len + close_ticks);
        fill_word(word, end_off);
      end else begin
        word            = '0;
        word.word_count = word_tally[POS_W-1:0];
      end
    end
    word.line_end = 1'b1;
    restart_line();
    if (ch == CH_NUL && !fin) scan_state = WAIT_LAST;
    return 1'b1;
  endfunction

  // Print one line per mismatch and count them all.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Predict on each accepted byte, then check each accepted result.
  always @(posedge clk) begin : check_proc
    res_t fresh, seen, want;
    if (!rst_n) begin
      restart_line();
    end else begin
      if (in_if.valid && in_if.ready) begin
        bytes_taken++;
        if (tokenize_byte(in_if.char_in, in_if.last, fresh))
          pending_words.push_back(drv_typed ? NO_WORD_END : fresh);
      end
      if (out_if.valid && out_if.ready) begin
        seen.word_valid   = out_if.word_valid;
        seen.word_start   = out_if.word_start;
        seen.word_length  = out_if.word_length;
        seen.word_end     = out_if.word_end;
        seen.quoted       = out_if.quoted;
        seen.quote_closed = out_if.quote_closed;
        seen.tick_quoted  = out_if.tick_quoted;
        seen.word_count   = out_if.word_count;
        seen.line_end     = out_if.line_end;
        if (pending_words.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(seen), 64'(0));
        end else begin
          want = pending_words.pop_front();
          if (want.word_valid) words_checked++;
          if (want.line_end) ends_checked++;
          if (seen.word_valid !== want.word_valid)
            report_mismatch("word_valid", 64'(seen.word_valid), 64'(want.word_valid));
          if (seen.word_start !== want.word_start)
            report_mismatch("word_start", 64'(seen.word_start), 64'(want.word_start));
          if (seen.word_length !== want.word_length)
            report_mismatch("word_length", 64'(seen.word_length), 64'(want.word_length));
          if (seen.word_end !== want.word_end)
            report_mismatch("word_end", 64'(seen.word_end), 64'(want.word_end));
          if (seen.quoted !== want.quoted)
            report_mismatch("quoted", 64'(seen.quoted), 64'(want.quoted));
          if (seen.quote_closed !== want.quote_closed)
            report_mismatch("quote_closed", 64'(seen.quote_closed),
                            64'(want.quote_closed));
          if (seen.tick_quoted !== want.tick_quoted)
            report_mismatch("tick_quoted", 64'(seen.tick_quoted), 64'(want.tick_quoted));
          if (seen.word_count !== want.word_count)
            report_mismatch("word_count", 64'(seen.word_count), 64'(want.word_count));
          if (seen.line_end !== want.line_end)
            report_mismatch("line_end", 64'(seen.line_end), 64'(want.line_end));
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) out_if.ready <= ($urandom_range(0, 99) >= stall_pct);

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, after a random gap, and wait until it is taken.
  task automatic push_byte(input logic [7:0] ch, input logic fin, input logic typed);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= ch;
    in_if.last    <= fin;
    drv_typed     <= typed;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // Any non-zero byte that is not a quote, a backtick or a backslash, nor a blank unless allow_blank.
  function automatic logic [7:0] pick_text(input bit allow_blank);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_DQUOTE || c == CH_BTICK || c == CH_BSLASH ||
           (!allow_blank && is_blank(c)));
    return c;
  endfunction

  // Build one random command line into line_q; junk counts ignored bytes.
  function automatic void build_line(output int unsigned junk);
    logic [7:0]  b[$];
    int unsigned words, run;
    junk = 0;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // Noise: any bytes at all.
      repeat ($urandom_range(1, 12)) b.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) b.push_back(pick_blank());
      words = $urandom_range(0, 5);
      for (int w = 0; w < words; w++) begin
        if (w != 0) repeat ($urandom_range(1, 3)) b.push_back(pick_blank());
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // Bare word, with escapes and stray quotes inside.
            if ($urandom_range(0, 7) == 0) begin
              b.push_back(CH_BSLASH);
              b.push_back(8'($urandom_range(1, 255)));
            end else begin
              b.push_back(pick_text(1'b0));
            end
            repeat ($urandom_range(0, 5)) begin
              case ($urandom_range(0, 9))
                0: begin
                  b.push_back(CH_BSLASH);
                  b.push_back(8'($urandom_range(1, 255)));
                end
                1:       b.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_BTICK);
                default: b.push_back(pick_text(1'b0));
              endcase
            end
          end
          4, 5: begin
            // Double-quoted word, mostly closed, sometimes with a tail.
            b.push_back(CH_DQUOTE);
            repeat ($urandom_range(0, 6)) begin
              case ($urandom_range(0, 7))
                0: begin
                  b.push_back(CH_BSLASH);
                  b.push_back(8'($urandom_range(1, 255)));
                end
                1:       b.push_back(CH_BTICK);
                default: b.push_back(pick_text(1'b1));
              endcase
            end
            if ($urandom_range(0, 9) != 0) begin
              b.push_back(CH_DQUOTE);
              if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) b.push_back(pick_text(1'b0));
            end
          end
          6, 7, 8: begin
            // Backtick word; now and then an opening run past the limit.
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 3);
            repeat (run) b.push_back(CH_BTICK);
            b.push_back(pick_text(1'b1));
            repeat ($urandom_range(0, 4)) begin
              if (run > 1 && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, run - 1)) b.push_back(CH_BTICK);
                b.push_back(pick_text(1'b1));
              end else begin
                b.push_back($urandom_range(0, 5) == 0 ? CH_BSLASH : pick_text(1'b1));
              end
            end
            if ($urandom_range(0, 6) != 0) repeat (run) b.push_back(CH_BTICK);
          end
          default: begin
            repeat ($urandom_range(1, 6)) b.push_back(8'($urandom_range(1, 255)));
          end
        endcase
      end
      // How the line ends.
      case ($urandom_range(0, 3))
        0: b.push_back(CH_NUL);
        1: if (b.size() == 0) b.push_back(CH_NUL);
        2: begin
          // Zero byte without last, then bytes that are drained.
          b.push_back(CH_NUL);
          junk = $urandom_range(1, 4);
          repeat (junk) b.push_back(8'($urandom_range(0, 255)));
        end
        default: b.push_back(pick_blank());
      endcase
    end
    foreach (b[i]) line_q.push_back('{char_in: b[i], last: (i == b.size() - 1)});
  endfunction

  // Stimulus: directed table, then three phases of random lines with different gap and stall rates.
  initial begin : stimulus
    int unsigned junk, sent;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.char_in <= '0;
    in_if.last    <= 1'b0;
    drv_typed     <= 1'b0;
    gap_pct   = 7;
    stall_pct = 85;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) push_byte(plan[i].ch, plan[i].fin, plan[i].typed);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 7;
          stall_pct = 85;
        end
        1: begin
          gap_pct   = 85;
          stall_pct = 7;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_line(junk);
        foreach (line_q[i]) push_byte(line_q[i].char_in, line_q[i].last, 1'b0);
        sent += line_q.size() - junk;
        lines_sent++;
      end
    end
    in_if.valid <= 1'b0;

    // Let every result come in, then wait for strays before the summary.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Fed %0d bytes over %0d random lines plus the directed table.",
             bytes_taken, lines_sent);
    $display("Checked %0d words and %0d line ends; %0d mismatches.",
             words_checked, ends_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
